>>> hw/rtl/eeprom_page_write_sdp_defines.svh
// assertion macros used by the eeprom page write sequencer
`ifndef EEPROM_PAGE_WRITE_SDP_DEFINES_SVH
`define EEPROM_PAGE_WRITE_SDP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define EPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define EPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/eps_pkg.sv
// shared types, constants and helpers for the eeprom page write block
package eps_pkg;

  localparam int ADDR_W    = 15;
  localparam int DATA_W    = 8;
  localparam int NS_W      = 26;
  localparam int PHASE_W   = 3;
  localparam int STEP_W    = 3;
  localparam int MEM_BYTES = 32768;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE     = 3'd0,
    PH_SEQ      = 3'd1,
    PH_UNLOCKED = 3'd2,
    PH_LOAD     = 3'd3,
    PH_CYCLE    = 3'd4
  } phase_t;

  localparam logic [REG_IDX_W-1:0] REG_PROTECT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOAD_WIN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WCYCLE  = 2'd2;

  localparam logic [NS_W-1:0] LOAD_WIN_RST = 26'd150000;
  localparam logic [NS_W-1:0] WCYCLE_RST   = 26'd10000000;

  localparam logic [ADDR_W-1:0] SDP_ADDR_A = 15'h5555;
  localparam logic [ADDR_W-1:0] SDP_ADDR_B = 15'h2AAA;
  localparam logic [DATA_W-1:0] SDP_DATA_A = 8'hAA;
  localparam logic [DATA_W-1:0] SDP_DATA_B = 8'h55;
  localparam logic [DATA_W-1:0] SDP_ENABLE = 8'hA0;
  localparam logic [DATA_W-1:0] SDP_DISABLE = 8'h80;
  localparam logic [DATA_W-1:0] SDP_DIS_END = 8'h20;
  localparam logic [DATA_W-1:0] TOGGLE_BIT = 8'h40;
  localparam logic [DATA_W-1:0] POLL_BIT   = 8'h80;
  localparam logic [DATA_W-1:0] ERASED     = 8'hFF;

  localparam logic [STEP_W-1:0] SEQ_NONE = 3'd0;
  localparam logic [STEP_W-1:0] SEQ_S1   = 3'd1;
  localparam logic [STEP_W-1:0] SEQ_S2   = 3'd2;
  localparam logic [STEP_W-1:0] SEQ_S3   = 3'd3;
  localparam logic [STEP_W-1:0] SEQ_S4   = 3'd4;
  localparam logic [STEP_W-1:0] SEQ_S5   = 3'd5;

  typedef struct packed {
    logic            prot_wr;
    logic            prot_val;
    logic [NS_W-1:0] load_win;
    logic [NS_W-1:0] wcycle;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic exec;
    logic tick_step;
    logic commit_step;
    logic commit_end;
    logic load_out;
    logic clear_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_tick;
    logic tick_done;
    logic tick_commit;
    logic commit_last;
    logic clear_last;
    logic out_free;
  } dp_sts_t;

  // does this write match the expected protection sequence step
  function automatic logic seq_ok(input logic [STEP_W-1:0] step,
                                  input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] data);
    logic ok;
    ok = 1'b0;
    case (step)
      SEQ_S1: ok = (addr == SDP_ADDR_B) && (data == SDP_DATA_B);
      SEQ_S2: ok = (addr == SDP_ADDR_A) && ((data == SDP_ENABLE) || (data == SDP_DISABLE));
      SEQ_S3: ok = (addr == SDP_ADDR_A) && (data == SDP_DATA_A);
      SEQ_S4: ok = (addr == SDP_ADDR_B) && (data == SDP_DATA_B);
      SEQ_S5: ok = (addr == SDP_ADDR_A) && (data == SDP_DIS_END);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

>>> hw/rtl/eps_ctrl.sv
// sequencer state machine for the eeprom page write block
`include "eeprom_page_write_sdp_defines.svh"

module eps_ctrl
  import eps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_EXEC,
    S_TICK,
    S_COMMIT,
    S_CEND,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: state_nxt = S_EXEC;
      S_EXEC: state_nxt = sts.op_tick ? S_TICK : S_RESULT;
      S_TICK: begin
        if (sts.tick_done) begin
          state_nxt = S_RESULT;
        end else if (sts.tick_commit) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts.commit_last) begin
          state_nxt = S_CEND;
        end
      end
      S_CEND: state_nxt = S_RESULT;
      S_RESULT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.accept      = (state_r == S_IDLE) && in_valid;
    cmd.prep        = (state_r == S_PREP);
    cmd.exec        = (state_r == S_EXEC);
    cmd.tick_step   = (state_r == S_TICK) && !sts.tick_done && !sts.tick_commit;
    cmd.commit_step = (state_r == S_COMMIT);
    cmd.commit_end  = (state_r == S_CEND);
    cmd.load_out    = (state_r == S_RESULT) && sts.out_free;
    cmd.clear_wr    = (state_r == S_CLEAR);
  end

  assign in_stall = (state_r != S_IDLE);

  `EPS_ASSERT_NXT(a_clear_exit, state_r == S_CLEAR && sts.clear_last, state_r == S_IDLE, "clearing pass did not hand over to idle")
  `EPS_ASSERT_IMP(a_commit_entry, $rose(state_r == S_COMMIT), $past(sts.tick_commit), "page commit started without an expired write cycle")
  `EPS_ASSERT_NXT(a_commit_exit, state_r == S_COMMIT && sts.commit_last, state_r == S_CEND, "page commit overran the page")

endmodule

>>> hw/rtl/eps_dp.sv
// datapath: protocol state, page buffer, timers and the byte array
module eps_dp
  import eps_pkg::*;
#(
  parameter int PAGE_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_sts_t           sts,
  input  cfg_t              cfg,
  input  logic [1:0]        in_op,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [DATA_W-1:0] in_wdata,
  input  logic [NS_W-1:0]   in_elapsed_ns,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_read_data,
  output logic [PHASE_W-1:0] out_write_phase,
  output logic              out_protect_on,
  output logic              out_dropped
);

  localparam int OFF_W  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int QSH    = ADDR_W + OFF_W;
  localparam int RCP_W  = ADDR_W + 2;
  localparam int PROD_W = QSH + ADDR_W;
  localparam longint unsigned RECIP = ((64'd1 << QSH) + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam logic [RCP_W-1:0] RECIP_C = RCP_W'(RECIP);

  logic [DATA_W-1:0] mem [MEM_BYTES];
  logic [DATA_W-1:0] pbuf [PAGE_BYTES];

  // item registers
  op_t               item_op_r, item_op_nxt;
  logic [ADDR_W-1:0] item_addr_r, item_addr_nxt;
  logic [DATA_W-1:0] item_wdata_r, item_wdata_nxt;
  logic [NS_W-1:0]   nanos_r, nanos_nxt;
  logic [ADDR_W-1:0] q_r, q_nxt;

  // protocol state
  phase_t            phase_r, phase_nxt;
  logic [STEP_W-1:0] seq_step_r, seq_step_nxt;
  logic              protect_r, protect_nxt;
  logic              unlock_r, unlock_nxt;
  logic [PAGE_BYTES-1:0] mask_r, mask_nxt;
  logic [ADDR_W-1:0] page_base_r, page_base_nxt;
  logic [DATA_W-1:0] last_wdata_r, last_wdata_nxt;
  logic [ADDR_W-1:0] last_waddr_r, last_waddr_nxt;
  logic [NS_W-1:0]   phase_time_r, phase_time_nxt;
  logic              rd_status_r, rd_status_nxt;
  logic              drop_r, drop_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_rd_r, out_rd_nxt;
  logic [PHASE_W-1:0] out_phase_r, out_phase_nxt;
  logic              out_prot_r, out_prot_nxt;
  logic              out_drop_r, out_drop_nxt;

  // commit pipeline and clearing sweep
  logic [OFF_W-1:0]  cidx_r, cidx_nxt;
  logic              cwr_valid_r;
  logic [ADDR_W-1:0] cwr_addr_r;
  logic [DATA_W-1:0] pbuf_rdata_r;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [DATA_W-1:0] arr_rdata_r;

  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] base;
  logic [OFF_W-1:0]  off;
  logic [PAGE_BYTES-1:0] off_bit;
  logic [NS_W-1:0]   limit;
  logic [NS_W-1:0]   left;
  logic              ns_ge;
  logic              buf_we;
  logic              commit_ok;
  logic              arr_we;
  logic [ADDR_W-1:0] arr_waddr;
  logic [DATA_W-1:0] arr_wdata;
  logic              arr_re;

  // page base by reciprocal multiply, exact for every 15-bit address
  assign prod    = PROD_W'(item_addr_r) * PROD_W'(RECIP_C);
  assign base    = q_r * ADDR_W'(PAGE_BYTES);
  assign off     = OFF_W'(item_addr_r - base);
  assign off_bit = PAGE_BYTES'(1) << off;

  assign limit = (phase_r == PH_CYCLE) ? cfg.wcycle : cfg.load_win;
  assign left  = (limit > phase_time_r) ? (limit - phase_time_r) : '0;
  assign ns_ge = (nanos_r >= left);
  assign commit_ok = !(protect_r && !unlock_r);

  always_comb begin
    item_op_nxt    = item_op_r;
    item_addr_nxt  = item_addr_r;
    item_wdata_nxt = item_wdata_r;
    nanos_nxt      = nanos_r;
    q_nxt          = q_r;
    phase_nxt      = phase_r;
    seq_step_nxt   = seq_step_r;
    protect_nxt    = protect_r;
    unlock_nxt     = unlock_r;
    mask_nxt       = mask_r;
    page_base_nxt  = page_base_r;
    last_wdata_nxt = last_wdata_r;
    last_waddr_nxt = last_waddr_r;
    phase_time_nxt = phase_time_r;
    rd_status_nxt  = rd_status_r;
    drop_nxt       = drop_r;
    cidx_nxt       = cidx_r;
    clr_cnt_nxt    = clr_cnt_r;
    buf_we         = 1'b0;

    if (cmd.accept) begin
      item_op_nxt    = op_t'(in_op);
      item_addr_nxt  = in_addr;
      item_wdata_nxt = in_wdata;
      nanos_nxt      = in_elapsed_ns;
    end

    if (cmd.prep) begin
      q_nxt = prod[QSH +: ADDR_W];
    end

    if (cmd.exec) begin
      rd_status_nxt = 1'b0;
      drop_nxt      = 1'b0;
      case (item_op_r)
        OP_READ: begin
          if ((phase_r != PH_IDLE) && (item_addr_r == last_waddr_r)) begin
            last_wdata_nxt = last_wdata_r ^ TOGGLE_BIT;
            rd_status_nxt  = 1'b1;
          end
        end
        OP_WRITE: begin
          case (phase_r)
            PH_IDLE: begin
              if ((item_addr_r == SDP_ADDR_A) && (item_wdata_r == SDP_DATA_A)) begin
                seq_step_nxt = SEQ_S1;
                phase_nxt    = PH_SEQ;
              end else begin
                phase_nxt = PH_LOAD;
              end
              page_base_nxt  = base;
              mask_nxt       = off_bit;
              phase_time_nxt = '0;
              buf_we         = 1'b1;
              last_waddr_nxt = item_addr_r;
              last_wdata_nxt = item_wdata_r;
            end
            PH_SEQ: begin
              phase_time_nxt = '0;
              if (!seq_ok(seq_step_r, item_addr_r, item_wdata_r)) begin
                seq_step_nxt = SEQ_NONE;
                phase_nxt    = PH_IDLE;
                drop_nxt     = 1'b1;
              end else begin
                if ((seq_step_r == SEQ_S2) && (item_wdata_r == SDP_ENABLE)) begin
                  protect_nxt  = 1'b1;
                  unlock_nxt   = 1'b1;
                  mask_nxt     = '0;
                  phase_nxt    = PH_UNLOCKED;
                  seq_step_nxt = SEQ_NONE;
                end else if (seq_step_r == SEQ_S5) begin
                  protect_nxt  = 1'b0;
                  mask_nxt     = '0;
                  phase_nxt    = PH_UNLOCKED;
                  seq_step_nxt = SEQ_NONE;
                end else begin
                  seq_step_nxt = seq_step_r + STEP_W'(1);
                end
                last_waddr_nxt = item_addr_r;
                last_wdata_nxt = item_wdata_r;
              end
            end
            PH_UNLOCKED: begin
              page_base_nxt  = base;
              mask_nxt       = off_bit;
              phase_time_nxt = '0;
              buf_we         = 1'b1;
              phase_nxt      = PH_LOAD;
              last_waddr_nxt = item_addr_r;
              last_wdata_nxt = item_wdata_r;
            end
            PH_LOAD: begin
              if (page_base_r != base) begin
                drop_nxt = 1'b1;
              end else begin
                mask_nxt       = mask_r | off_bit;
                phase_time_nxt = '0;
                buf_we         = 1'b1;
                last_waddr_nxt = item_addr_r;
                last_wdata_nxt = item_wdata_r;
              end
            end
            default: begin
              // write cycle busy: ignored, but status polling follows it
              last_waddr_nxt = item_addr_r;
              last_wdata_nxt = item_wdata_r;
            end
          endcase
        end
        default: ;
      endcase
    end

    // one phase per step; an expired write cycle is handled by the commit
    if (cmd.tick_step) begin
      if (ns_ge) begin
        nanos_nxt = nanos_r - left;
        if (phase_r == PH_SEQ) begin
          seq_step_nxt = SEQ_NONE;
        end
        phase_nxt      = PH_CYCLE;
        phase_time_nxt = '0;
      end else begin
        phase_time_nxt = phase_time_r + nanos_r;
        nanos_nxt      = '0;
      end
    end

    if (cmd.commit_step) begin
      cidx_nxt = cidx_r + OFF_W'(1);
    end

    if (cmd.commit_end) begin
      unlock_nxt     = 1'b0;
      phase_nxt      = PH_IDLE;
      phase_time_nxt = '0;
      cidx_nxt       = '0;
      nanos_nxt      = '0;
    end

    if (cfg.prot_wr && (phase_r == PH_IDLE)) begin
      protect_nxt = cfg.prot_val;
    end

    if (cmd.clear_wr) begin
      clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_phase_nxt = out_phase_r;
    out_prot_nxt  = out_prot_r;
    out_drop_nxt  = out_drop_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      if (item_op_r == OP_READ) begin
        out_rd_nxt = rd_status_r ? (last_wdata_r ^ POLL_BIT) : arr_rdata_r;
      end else begin
        out_rd_nxt = '0;
      end
      out_phase_nxt = phase_r;
      out_prot_nxt  = protect_r;
      out_drop_nxt  = drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      seq_step_r   <= SEQ_NONE;
      protect_r    <= 1'b0;
      unlock_r     <= 1'b0;
      mask_r       <= '0;
      page_base_r  <= '0;
      last_wdata_r <= '0;
      last_waddr_r <= '0;
      phase_time_r <= '0;
      cidx_r       <= '0;
      cwr_valid_r  <= 1'b0;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      seq_step_r   <= seq_step_nxt;
      protect_r    <= protect_nxt;
      unlock_r     <= unlock_nxt;
      mask_r       <= mask_nxt;
      page_base_r  <= page_base_nxt;
      last_wdata_r <= last_wdata_nxt;
      last_waddr_r <= last_waddr_nxt;
      phase_time_r <= phase_time_nxt;
      cidx_r       <= cidx_nxt;
      cwr_valid_r  <= cmd.commit_step && mask_r[cidx_r] && commit_ok;
      clr_cnt_r    <= clr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_op_r    <= item_op_nxt;
    item_addr_r  <= item_addr_nxt;
    item_wdata_r <= item_wdata_nxt;
    nanos_r      <= nanos_nxt;
    q_r          <= q_nxt;
    rd_status_r  <= rd_status_nxt;
    drop_r       <= drop_nxt;
    cwr_addr_r   <= page_base_r + ADDR_W'(cidx_r);
    out_rd_r     <= out_rd_nxt;
    out_phase_r  <= out_phase_nxt;
    out_prot_r   <= out_prot_nxt;
    out_drop_r   <= out_drop_nxt;
  end

  // page buffer: byte loads write, the commit sweep reads
  always_ff @(posedge clk) begin
    if (buf_we) begin
      pbuf[off] <= item_wdata_r;
    end
    if (cmd.commit_step) begin
      pbuf_rdata_r <= pbuf[cidx_r];
    end
  end

  // byte array: clearing sweep, commit writes and preloads share one port
  always_comb begin
    arr_we    = 1'b0;
    arr_waddr = item_addr_r;
    arr_wdata = item_wdata_r;
    if (cmd.clear_wr) begin
      arr_we    = 1'b1;
      arr_waddr = clr_cnt_r;
      arr_wdata = ERASED;
    end else if (cwr_valid_r) begin
      arr_we    = 1'b1;
      arr_waddr = cwr_addr_r;
      arr_wdata = pbuf_rdata_r;
    end else if (cmd.exec && (item_op_r == OP_LOAD)) begin
      arr_we = 1'b1;
    end
  end

  assign arr_re = cmd.exec && (item_op_r == OP_READ);

  always_ff @(posedge clk) begin
    if (arr_we) begin
      mem[arr_waddr] <= arr_wdata;
    end
    if (arr_re) begin
      arr_rdata_r <= mem[item_addr_r];
    end
  end

  always_comb begin
    sts             = '0;
    sts.op_tick     = (item_op_r == OP_TICK);
    sts.tick_done   = (phase_r == PH_IDLE) || (nanos_r == '0);
    sts.tick_commit = (phase_r == PH_CYCLE) && ns_ge;
    sts.commit_last = (cidx_r == OFF_W'(PAGE_BYTES - 1));
    sts.clear_last  = (clr_cnt_r == ADDR_W'(MEM_BYTES - 1));
    sts.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_rd_r;
  assign out_write_phase = out_phase_r;
  assign out_protect_on  = out_prot_r;
  assign out_dropped     = out_drop_r;

endmodule

>>> hw/rtl/eeprom_page_write_sdp.sv
// top level: eeprom page write with software data protection
// read, write and preload requests go from accept through the prep, exec
// and result states to out_valid, one at a time; tick requests add a step
// per phase passed and, on write cycle expiry, a page commit sweep
// after reset a clearing pass writes 0xFF to all 32768 bytes, one per cycle;
// in_stall stays high for the whole pass, register writes are taken
module eeprom_page_write_sdp
  import eps_pkg::*;
#(
  parameter int PAGE_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [ADDR_W-1:0]  in_addr,
  input  logic [DATA_W-1:0]  in_wdata,
  input  logic [NS_W-1:0]    in_elapsed_ns,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  out_read_data,
  output logic [PHASE_W-1:0] out_write_phase,
  output logic               out_protect_on,
  output logic               out_dropped
);

  logic                 prot_en_r, prot_en_nxt;
  logic [NS_W-1:0]      load_win_r, load_win_nxt;
  logic [NS_W-1:0]      wcycle_r, wcycle_nxt;
  logic                 reg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  cfg_t                 cfg;
  ctrl_cmd_t            cmd;
  dp_sts_t              sts;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    prot_en_nxt  = prot_en_r;
    load_win_nxt = load_win_r;
    wcycle_nxt   = wcycle_r;
    if (reg_wr) begin
      case (reg_idx)
        REG_PROTECT:  prot_en_nxt  = pwdata[0];
        REG_LOAD_WIN: load_win_nxt = pwdata[NS_W-1:0];
        REG_WCYCLE:   wcycle_nxt   = pwdata[NS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot_en_r  <= 1'b0;
      load_win_r <= LOAD_WIN_RST;
      wcycle_r   <= WCYCLE_RST;
    end else begin
      prot_en_r  <= prot_en_nxt;
      load_win_r <= load_win_nxt;
      wcycle_r   <= wcycle_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PROTECT:  prdata = PDATA_W'(prot_en_r);
      REG_LOAD_WIN: prdata = PDATA_W'(load_win_r);
      REG_WCYCLE:   prdata = PDATA_W'(wcycle_r);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    cfg          = '0;
    cfg.prot_wr  = reg_wr && (reg_idx == REG_PROTECT);
    cfg.prot_val = pwdata[0];
    cfg.load_win = load_win_r;
    cfg.wcycle   = wcycle_r;
  end

  eps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  eps_dp #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg             (cfg),
    .in_op           (in_op),
    .in_addr         (in_addr),
    .in_wdata        (in_wdata),
    .in_elapsed_ns   (in_elapsed_ns),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_write_phase (out_write_phase),
    .out_protect_on  (out_protect_on),
    .out_dropped     (out_dropped)
  );

endmodule
